### hdl/block_admission_word_fifo_top_defines.svh
// Assertion macros shared by the word FIFO modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef BLOCK_ADMISSION_WORD_FIFO_TOP_DEFINES_SVH
`define BLOCK_ADMISSION_WORD_FIFO_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BAWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define BAWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bawf_pkg.sv
// Shared widths, codes and controller/datapath handoff types for the word FIFO.
// Depends on nothing; every other file of the block but the assertion macro header uses it.
package bawf_pkg;

	localparam int DEPTH_DEF    = 1024;
	localparam int MAX_READ_DEF = 64;

	localparam int BYTE_W     = 8;
	localparam int WORD_W     = 16;
	localparam int FUNC_W     = 3;
	localparam int COUNT_W    = 11;
	localparam int STATUS_W   = 2;
	localparam int SIZE_W     = 11;
	localparam int MRL_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;
	localparam logic [MRL_W-1:0]  MRL_RST  = 7'd64;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE  = 3'd0,
		FUNC_READ   = 3'd1,
		FUNC_PEEK   = 3'd2,
		FUNC_COMMIT = 3'd3,
		FUNC_RESET  = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERRUN  = 2'd1,
		STAT_SHORT    = 2'd2,
		STAT_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUFFER_SIZE     = 1'b0,
		CFG_MAX_READ_LENGTH = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic emit_word;
		logic commit_step;
		logic commit_finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic start_stream;
		logic start_commit;
		logic emit_last;
		logic commit_wrap;
	} dp_stat_t;

endpackage

### hdl/bawf_req_if.sv
// Request channel of the word FIFO: valid/ready plus one request item.
// Depends on bawf_pkg for field widths.
interface bawf_req_if;
	logic                         valid;
	logic                         ready;
	logic [bawf_pkg::FUNC_W-1:0]  func;
	logic [bawf_pkg::BYTE_W-1:0]  low_byte;
	logic [bawf_pkg::BYTE_W-1:0]  high_byte;
	logic                         burst_first;
	logic [bawf_pkg::COUNT_W-1:0] count;

	modport source (output valid, func, low_byte, high_byte, burst_first, count, input ready);
	modport sink (input valid, func, low_byte, high_byte, burst_first, count, output ready);
endinterface

### hdl/bawf_rsp_if.sv
// Result channel of the word FIFO: valid/ready plus one result item.
// Depends on bawf_pkg for field widths.
interface bawf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bawf_pkg::WORD_W-1:0]   word;
	logic [bawf_pkg::STATUS_W-1:0] status;
	logic                          last;
	logic                          has_word;
	logic [bawf_pkg::SIZE_W-1:0]   words_used;

	modport source (output valid, word, status, last, has_word, words_used, input ready);
	modport sink (input valid, word, status, last, has_word, words_used, output ready);
endinterface

### hdl/bawf_cfg_if.sv
// Configuration write channel of the word FIFO: valid/ready, register index and data.
// Depends on bawf_pkg for field widths.
interface bawf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bawf_pkg::CFG_IDX_W-1:0]  index;
	logic [bawf_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/bawf_dpath.sv
// Datapath of the word FIFO: word store, pointers, counts, config registers, result register.
// Depends on bawf_pkg and the assertion macros; driven by bawf_ctrl commands.
`include "block_admission_word_fifo_top_defines.svh"

module bawf_dpath #(
	parameter int DEPTH    = bawf_pkg::DEPTH_DEF,
	parameter int MAX_READ = bawf_pkg::MAX_READ_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bawf_pkg::dp_cmd_t               cmd,
	output bawf_pkg::dp_stat_t              stat,
	input  logic [bawf_pkg::FUNC_W-1:0]     func,
	input  logic [bawf_pkg::BYTE_W-1:0]     low_byte,
	input  logic [bawf_pkg::BYTE_W-1:0]     high_byte,
	input  logic                            burst_first,
	input  logic [bawf_pkg::COUNT_W-1:0]    count,
	input  logic                            cfg_we,
	input  logic [bawf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bawf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [bawf_pkg::WORD_W-1:0]     word,
	output logic [bawf_pkg::STATUS_W-1:0]   status,
	output logic                            last,
	output logic                            has_word,
	output logic [bawf_pkg::SIZE_W-1:0]     words_used
);

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int PP_W    = $clog2(MAX_READ + 1);
	localparam int CP_W    = PTR_W + 1;
	localparam int TAKEN_W = bawf_pkg::SIZE_W + 1;

	function automatic logic [PTR_W-1:0] next_pos(
		input logic [PTR_W-1:0]            p,
		input logic [bawf_pkg::SIZE_W-1:0] s
	);
		return ((32'(p) + 32'd1) >= 32'(s)) ? '0 : p + 1'b1;
	endfunction

	logic [bawf_pkg::WORD_W-1:0] mem [DEPTH];

	logic [PTR_W-1:0]            wp_q;
	logic [PTR_W-1:0]            rp_q;
	logic [bawf_pkg::SIZE_W-1:0] used_q;
	logic [PP_W-1:0]             pp_q;
	logic                        bacc_q;
	logic [bawf_pkg::SIZE_W-1:0] size_cfg_q;
	logic [bawf_pkg::MRL_W-1:0]  mrl_q;
	logic [PTR_W-1:0]            eptr_q;
	logic [PP_W-1:0]             rem_q;
	logic                        is_read_q;
	logic [CP_W-1:0]             cp_q;

	logic                        rsp_valid_q;
	logic [bawf_pkg::WORD_W-1:0] word_q;
	bawf_pkg::status_t           status_q;
	logic                        last_q;
	logic                        has_word_q;
	logic [bawf_pkg::SIZE_W-1:0] words_used_q;

	logic [bawf_pkg::SIZE_W-1:0]  size_use;
	logic [TAKEN_W-1:0]           taken;
	logic [bawf_pkg::SIZE_W-1:0]  free;
	logic [bawf_pkg::MRL_W-1:0]   peek_limit;
	logic [bawf_pkg::COUNT_W-1:0] req_limit;
	logic                         too_long;
	logic                         short_data;
	logic                         bacc_new;
	logic                         wr_ok;
	logic                         mem_we;
	logic                         known_func;
	logic                         load;
	logic [bawf_pkg::SIZE_W-1:0]  used_nx;
	bawf_pkg::status_t            res_status;

	// Size in use: zero acts as one, anything above the store acts as the store depth.
	always_comb begin
		if (size_cfg_q == '0) begin
			size_use = bawf_pkg::SIZE_W'(1);
		end else if (32'(size_cfg_q) > DEPTH) begin
			size_use = bawf_pkg::SIZE_W'(DEPTH);
		end else begin
			size_use = size_cfg_q;
		end
	end

	assign taken = TAKEN_W'(used_q) + TAKEN_W'(pp_q);
	assign free  = (taken >= TAKEN_W'(size_use)) ? '0
		: bawf_pkg::SIZE_W'(TAKEN_W'(size_use) - taken);

	assign peek_limit = (32'(mrl_q) > MAX_READ) ? bawf_pkg::MRL_W'(MAX_READ) : mrl_q;
	assign req_limit  = (func == bawf_pkg::FUNC_READ) ? bawf_pkg::COUNT_W'(MAX_READ)
		: bawf_pkg::COUNT_W'(peek_limit);
	assign too_long   = count > req_limit;
	assign short_data = (pp_q != '0) || (count > used_q);

	assign bacc_new = burst_first ? (count <= free) : bacc_q;
	assign wr_ok    = bacc_new && (free != '0);
	assign mem_we   = cmd.take && (func == bawf_pkg::FUNC_WRITE) && wr_ok;

	assign known_func = (func == bawf_pkg::FUNC_WRITE) || (func == bawf_pkg::FUNC_READ) ||
		(func == bawf_pkg::FUNC_PEEK) || (func == bawf_pkg::FUNC_COMMIT) ||
		(func == bawf_pkg::FUNC_RESET);

	assign stat.out_free     = !rsp_valid_q || rsp_ready;
	assign stat.start_stream = ((func == bawf_pkg::FUNC_READ) || (func == bawf_pkg::FUNC_PEEK)) &&
		!too_long && !short_data && (count != '0);
	assign stat.start_commit = (func == bawf_pkg::FUNC_COMMIT);
	assign stat.emit_last    = (rem_q == PP_W'(1));
	assign stat.commit_wrap  = (32'(cp_q) >= 32'(size_use));

	assign load = (cmd.take && known_func && !stat.start_stream && !stat.start_commit) ||
		cmd.emit_word || cmd.commit_finish;

	// Used count after this cycle; a stream takes its words off at the start.
	always_comb begin
		used_nx    = used_q;
		res_status = bawf_pkg::STAT_OK;
		if (cmd.take) begin
			unique case (func)
				bawf_pkg::FUNC_WRITE: begin
					if (wr_ok) begin
						used_nx = used_q + 1'b1;
					end else begin
						res_status = bawf_pkg::STAT_OVERRUN;
					end
				end
				bawf_pkg::FUNC_READ, bawf_pkg::FUNC_PEEK: begin
					if (too_long) begin
						res_status = bawf_pkg::STAT_TOO_LONG;
					end else if (short_data) begin
						res_status = bawf_pkg::STAT_SHORT;
					end else begin
						used_nx = used_q - bawf_pkg::SIZE_W'(count);
					end
				end
				bawf_pkg::FUNC_RESET: begin
					used_nx = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			used_q      <= '0;
			pp_q        <= '0;
			bacc_q      <= 1'b0;
			size_cfg_q  <= bawf_pkg::SIZE_RST;
			mrl_q       <= bawf_pkg::MRL_RST;
			eptr_q      <= '0;
			rem_q       <= '0;
			is_read_q   <= 1'b0;
			cp_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			used_q <= used_nx;

			if (cfg_we) begin
				unique case (bawf_pkg::cfg_idx_t'(cfg_index))
					bawf_pkg::CFG_BUFFER_SIZE:     size_cfg_q <= cfg_data;
					bawf_pkg::CFG_MAX_READ_LENGTH: mrl_q <= cfg_data[bawf_pkg::MRL_W-1:0];
				endcase
			end

			if (cmd.take) begin
				unique case (func)
					bawf_pkg::FUNC_WRITE: begin
						if (burst_first) begin
							bacc_q <= bacc_new;
						end
						if (wr_ok) begin
							wp_q <= next_pos(wp_q, size_use);
						end
					end
					bawf_pkg::FUNC_READ, bawf_pkg::FUNC_PEEK: begin
						if (stat.start_stream) begin
							eptr_q    <= rp_q;
							rem_q     <= PP_W'(count);
							is_read_q <= (func == bawf_pkg::FUNC_READ);
							if (func == bawf_pkg::FUNC_PEEK) begin
								pp_q <= PP_W'(count);
							end
						end
					end
					bawf_pkg::FUNC_COMMIT: begin
						cp_q <= CP_W'(rp_q) + CP_W'(pp_q);
					end
					bawf_pkg::FUNC_RESET: begin
						wp_q   <= '0;
						rp_q   <= '0;
						pp_q   <= '0;
						bacc_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end

			// Advance one word per emitted result; a read frees its words at the end.
			if (cmd.emit_word) begin
				eptr_q <= next_pos(eptr_q, size_use);
				rem_q  <= rem_q - 1'b1;
				if (stat.emit_last && is_read_q) begin
					rp_q <= next_pos(eptr_q, size_use);
				end
			end

			if (cmd.commit_step) begin
				cp_q <= CP_W'(32'(cp_q) - 32'(size_use));
			end
			if (cmd.commit_finish) begin
				rp_q <= PTR_W'(cp_q);
				pp_q <= '0;
			end

			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Store write port, registered store read, result payload.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= {high_byte, low_byte};
		end
		if (load) begin
			word_q       <= cmd.emit_word ? mem[eptr_q] : '0;
			has_word_q   <= cmd.emit_word;
			last_q       <= cmd.emit_word ? stat.emit_last : 1'b1;
			status_q     <= res_status;
			words_used_q <= used_nx;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign word       = word_q;
	assign status     = status_q;
	assign last       = last_q;
	assign has_word   = has_word_q;
	assign words_used = words_used_q;

	`BAWF_ASSERT_NOW(a_word_status_ok, clk, arst_n, rsp_valid_q && has_word_q, status_q == bawf_pkg::STAT_OK, "data result carries a non-ok status")
	`BAWF_ASSERT_NOW(a_emit_has_words, clk, arst_n, cmd.emit_word, rem_q != '0, "word emitted with no words remaining")
	`BAWF_ASSERT_NEXT(a_emit_drains, clk, arst_n, cmd.emit_word && stat.emit_last, rem_q == '0, "remaining count not drained after last word")

endmodule

### hdl/bawf_ctrl.sv
// Controller of the word FIFO: sequences request intake, word streaming and commit wrap.
// Depends on bawf_pkg and the assertion macros; commands bawf_dpath.
`include "block_admission_word_fifo_top_defines.svh"

module bawf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  bawf_pkg::dp_stat_t stat,
	output bawf_pkg::dp_cmd_t  cmd
);

	bawf_pkg::state_t state_q;
	bawf_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bawf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			bawf_pkg::ST_IDLE: begin
				req_ready = stat.out_free;
				if (req_valid && stat.out_free) begin
					cmd.take = 1'b1;
					if (stat.start_stream) begin
						state_nx = bawf_pkg::ST_EMIT;
					end else if (stat.start_commit) begin
						state_nx = bawf_pkg::ST_COMMIT;
					end
				end
			end
			bawf_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_word = 1'b1;
					if (stat.emit_last) begin
						state_nx = bawf_pkg::ST_IDLE;
					end
				end
			end
			bawf_pkg::ST_COMMIT: begin
				if (stat.commit_wrap) begin
					cmd.commit_step = 1'b1;
				end else if (stat.out_free) begin
					cmd.commit_finish = 1'b1;
					state_nx          = bawf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = bawf_pkg::ST_IDLE;
			end
		endcase
	end

	`BAWF_ASSERT_NOW(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(cmd), "more than one datapath command at once")
	`BAWF_ASSERT_NOW(a_busy_blocks_req, clk, arst_n, state_q != bawf_pkg::ST_IDLE, !req_ready, "request taken while busy")
	`BAWF_ASSERT_NEXT(a_stream_starts, clk, arst_n, cmd.take && stat.start_stream, state_q == bawf_pkg::ST_EMIT, "stream request did not start emission")

endmodule

### hdl/block_admission_word_fifo_top.sv
// Top level of the block-admission word FIFO: wires the channels to controller and datapath.
// Depends on bawf_pkg, the three channel interfaces, bawf_ctrl and bawf_dpath.
//
// A circular FIFO of 16-bit words held in one single-port-read store of DEPTH words.
// The next request is accepted once the work on the last one is done and the result
// register is free or being taken. A write word, reset item, unknown code, or refused or
// zero-length read/peek is done at intake; a read or peek of n words then emits one word
// per cycle while the result register can advance, paced by the store's read port, whose
// registered read data is the result register itself; a commit wraps its pointer in a
// compare-and-subtract loop, k = floor((read_pointer + pending_peek) / size_in_use) times,
// which is 0 or 1 whenever the size has not been changed under live pointers. A stalled
// result channel holds the block in place; nothing is lost or repeated.
// Write bursts are admitted on their first item when the announced count fits the free
// space (size in use minus stored words minus peeked words); words of a refused burst, or
// words that find the buffer full, come back with status overrun. Unknown codes yield no
// result, a started read or peek one per word with last set on the final one, every other
// request exactly one; words_used on every result is the count left after the request.
// Configuration writes (buffer size, peek limit) are always taken, one per cycle, and
// must only be issued while the block is idle. The store needs no clearing after reset.
module block_admission_word_fifo_top #(
	parameter int DEPTH    = bawf_pkg::DEPTH_DEF,
	parameter int MAX_READ = bawf_pkg::MAX_READ_DEF
) (
	input logic         clk,
	input logic         arst_n,
	bawf_req_if.sink    req,
	bawf_rsp_if.source  rsp,
	bawf_cfg_if.sink    cfg
);

	bawf_pkg::dp_cmd_t  cmd;
	bawf_pkg::dp_stat_t stat;
	logic               req_ready;

	// Config registers sit in plain flops: accept every write at once.
	assign cfg.ready = 1'b1;
	assign req.ready = req_ready;

	// Controller: takes a request only when idle and the result register can advance.
	bawf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: store, pointers, admission and status logic, result register.
	bawf_dpath #(
		.DEPTH    (DEPTH),
		.MAX_READ (MAX_READ)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.func        (req.func),
		.low_byte    (req.low_byte),
		.high_byte   (req.high_byte),
		.burst_first (req.burst_first),
		.count       (req.count),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.word        (rsp.word),
		.status      (rsp.status),
		.last        (rsp.last),
		.has_word    (rsp.has_word),
		.words_used  (rsp.words_used)
	);

endmodule
